### rtl/core/sst_pkg.sv
`timescale 1ns / 1ps

package sst_pkg;

    localparam int CAPACITY  = 16;
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int CMD_W     = 3;
    localparam int KEY_W     = 32;
    localparam int PAYLOAD_W = 48;
    localparam int STATUS_W  = 2;
    localparam int COUNT_W   = 5;

    localparam logic [CMD_W-1:0] CMD_INS_FRONT  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INS_END    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_INS_SORTED = 3'd2;
    localparam logic [CMD_W-1:0] CMD_REM_END    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_REM_FRONT  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_REM_KEY    = 3'd5;

    localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic             load;
        logic             shift_in;
        logic             shift_out;
        logic [CMD_W-1:0] command;
    } cell_ctl_t;

endpackage

### rtl/core/sst_if.sv
`timescale 1ns / 1ps

interface sst_req_if;
    import sst_pkg::*;

    logic                        valid;
    logic                        ready;
    logic [CMD_W-1:0]            command;
    logic signed [KEY_W-1:0]     key;
    logic [PAYLOAD_W-1:0]        payload;

    modport source (output valid, command, key, payload, input ready);
    modport sink   (input valid, command, key, payload, output ready);
endinterface

interface sst_rsp_if;
    import sst_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count;
    logic                is_empty;
    logic                is_full;

    modport source (output valid, status, count, is_empty, is_full, input ready);
    modport sink   (input valid, status, count, is_empty, is_full, output ready);
endinterface

### rtl/core/sst_cell.sv
`timescale 1ns / 1ps

module sst_cell (
    input  logic                             clk,
    input  sst_pkg::cell_ctl_t               ctl,
    input  logic                             occ,
    input  logic signed [sst_pkg::KEY_W-1:0] in_key,
    input  logic signed [sst_pkg::KEY_W-1:0] new_key,
    input  logic [sst_pkg::PAYLOAD_W-1:0]    new_payload,
    input  logic signed [sst_pkg::KEY_W-1:0] left_key,
    input  logic [sst_pkg::PAYLOAD_W-1:0]    left_payload,
    input  logic signed [sst_pkg::KEY_W-1:0] right_key,
    input  logic [sst_pkg::PAYLOAD_W-1:0]    right_payload,
    input  logic                             seen_in,
    output logic                             seen_out,
    output logic signed [sst_pkg::KEY_W-1:0] key_q,
    output logic [sst_pkg::PAYLOAD_W-1:0]    payload_q
);
    import sst_pkg::*;

    logic signed [KEY_W-1:0] key_reg, key_next;
    logic [PAYLOAD_W-1:0]    payload_reg, payload_next;
    logic                    lt_reg;
    logic                    eq_reg;
    logic                    cand;
    logic                    at;

    // cand marks a cell that could be the target; the first one in the row wins
    always_comb
    begin
        case (ctl.command)
            CMD_INS_FRONT:  cand = 1'b1;
            CMD_REM_FRONT:  cand = 1'b1;
            CMD_INS_END:    cand = !occ;
            CMD_INS_SORTED: cand = !occ || !lt_reg;
            CMD_REM_KEY:    cand = occ && eq_reg;
            default:        cand = 1'b0;
        endcase
    end

    assign at       = cand && !seen_in;
    assign seen_out = seen_in || cand;

    always_comb
    begin
        key_next     = key_reg;
        payload_next = payload_reg;
        if (ctl.shift_in)
        begin
            if (at)
            begin
                key_next     = new_key;
                payload_next = new_payload;
            end
            else if (seen_in)
            begin
                key_next     = left_key;
                payload_next = left_payload;
            end
        end
        else if (ctl.shift_out && (at || seen_in))
        begin
            key_next     = right_key;
            payload_next = right_payload;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg     <= key_next;
        payload_reg <= payload_next;
        if (ctl.load)
        begin
            lt_reg <= key_reg < in_key;
            eq_reg <= key_reg == in_key;
        end
    end

    assign key_q     = key_reg;
    assign payload_q = payload_reg;

endmodule

### rtl/core/sorted_shift_table.sv
`timescale 1ns / 1ps

// Channel | Dir | Beat carries
// --------+-----+----------------------------------------
// req     | in  | command, key, payload
// rsp     | out | status, count, is_empty, is_full
//
// Each command is latched in IDLE, which also registers the key compares in every
// cell; EXEC then runs the target chain along the row and shifts.
// Reset clears the count; cell contents are undefined until written.
// A waiting response holds EXEC; req is taken again once it executes.

module sorted_shift_table (
    input  logic      clk,
    input  logic      rst_n,
    sst_req_if.sink   req,
    sst_rsp_if.source rsp
);
    import sst_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic                    state_reg, state_next;
    logic [CMD_W-1:0]        cmd_reg;
    logic signed [KEY_W-1:0] key_reg;
    logic [PAYLOAD_W-1:0]    payload_reg;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic                    out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]     status_reg, status_next;
    logic [COUNT_W-1:0]      out_count_reg;
    logic                    empty_reg, full_reg;

    logic                    accept;
    logic                    exec_fire;
    logic                    tbl_full;
    logic                    tbl_empty;
    logic                    found;
    cell_ctl_t               ctl;

    logic [CAPACITY-1:0]     occ;
    logic [CAPACITY:0]       seen;
    logic signed [KEY_W-1:0] cell_key [CAPACITY];
    logic [PAYLOAD_W-1:0]    cell_payload [CAPACITY];

    assign req.ready = (state_reg == ST_IDLE);
    assign accept    = req.valid && req.ready;
    assign exec_fire = (state_reg == ST_EXEC) && (!out_valid_reg || rsp.ready);

    assign tbl_full  = (count_reg == CNT_W'(CAPACITY));
    assign tbl_empty = (count_reg == '0);
    assign found     = seen[CAPACITY];

    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            occ[i] = CNT_W'(i) < count_reg;
        end
    end

    always_comb
    begin
        status_next   = ST_DONE;
        count_next    = count_reg;
        ctl.load      = accept;
        ctl.shift_in  = 1'b0;
        ctl.shift_out = 1'b0;
        ctl.command   = cmd_reg;
        case (cmd_reg)
            CMD_INS_FRONT, CMD_INS_END, CMD_INS_SORTED:
            begin
                if (tbl_full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    ctl.shift_in = exec_fire;
                    count_next   = count_reg + 1'b1;
                end
            end
            CMD_REM_END:
            begin
                if (tbl_empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    count_next = count_reg - 1'b1;
                end
            end
            CMD_REM_FRONT:
            begin
                if (tbl_empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    ctl.shift_out = exec_fire;
                    count_next    = count_reg - 1'b1;
                end
            end
            CMD_REM_KEY:
            begin
                if (tbl_empty)
                begin
                    status_next = ST_EMPTY;
                end
                else if (!found)
                begin
                    status_next = ST_NOT_FOUND;
                end
                else
                begin
                    ctl.shift_out = exec_fire;
                    count_next    = count_reg - 1'b1;
                end
            end
            default:
            begin
                status_next = ST_DONE;
            end
        endcase
    end

    always_comb
    begin
        case (state_reg)
            ST_IDLE: state_next = accept ? ST_EXEC : ST_IDLE;
            ST_EXEC: state_next = exec_fire ? ST_IDLE : ST_EXEC;
            default: state_next = ST_IDLE;
        endcase
    end

    assign out_valid_next = exec_fire ? 1'b1 : (rsp.ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (exec_fire)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg     <= req.command;
            key_reg     <= req.key;
            payload_reg <= req.payload;
        end
        if (exec_fire)
        begin
            status_reg    <= status_next;
            out_count_reg <= COUNT_W'(count_next);
            empty_reg     <= (count_next == '0);
            full_reg      <= (count_next == CNT_W'(CAPACITY));
        end
    end

    assign seen[0] = 1'b0;

    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic signed [KEY_W-1:0] lk, rk;
        logic [PAYLOAD_W-1:0]    lp, rp;

        if (g == 0)
        begin : g_first
            assign lk = key_reg;
            assign lp = payload_reg;
        end
        else
        begin : g_mid
            assign lk = cell_key[g-1];
            assign lp = cell_payload[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_last
            assign rk = cell_key[g];
            assign rp = cell_payload[g];
        end
        else
        begin : g_body
            assign rk = cell_key[g+1];
            assign rp = cell_payload[g+1];
        end

        sst_cell u_cell (
            .clk           (clk),
            .ctl           (ctl),
            .occ           (occ[g]),
            .in_key        (req.key),
            .new_key       (key_reg),
            .new_payload   (payload_reg),
            .left_key      (lk),
            .left_payload  (lp),
            .right_key     (rk),
            .right_payload (rp),
            .seen_in       (seen[g]),
            .seen_out      (seen[g+1]),
            .key_q         (cell_key[g]),
            .payload_q     (cell_payload[g])
        );
    end

    assign rsp.valid    = out_valid_reg;
    assign rsp.status   = status_reg;
    assign rsp.count    = out_count_reg;
    assign rsp.is_empty = empty_reg;
    assign rsp.is_full  = full_reg;

endmodule
